@@ src/hwp_pkg.sv @@
// shared types, codes and constants of the hex wildcard pattern parser
package hwp_pkg;

  // default bound on the configured capacity
  localparam int unsigned MAX_CAPACITY_DEF = 4096;
  // capacity after reset
  localparam int unsigned CAP_RESET = 256;

  // field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TOTAL_W = 13;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

  // character classes from the front decode
  localparam logic [1:0] CLS_NIB = 2'd0;
  localparam logic [1:0] CLS_SEP = 2'd1;
  localparam logic [1:0] CLS_NUL = 2'd2;
  localparam logic [1:0] CLS_BAD = 2'd3;

  // back-end phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HELD    = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  // special characters
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_WILD  = 8'h3F;

  // output queue depth, room for two results per back step
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);

  // classified character
  typedef struct packed {
    logic [1:0] cls;
    logic [3:0] nib;
    logic       wild;
  } item_t;

  // one result
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  value;
    logic [BYTE_W-1:0]  mask;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } res_t;

  // results written by one back step
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } oq_wr_t;

endpackage

@@ src/hwp_front.sv @@
// front end: accepts characters, classifies them and queues them for the back end
module hwp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [hwp_pkg::CHAR_W-1:0] char_in_i,
  output logic                      head_valid_o,
  output hwp_pkg::item_t            head_o,
  input  logic                      pop_i
);

  hwp_pkg::item_t item;
  hwp_pkg::item_t q_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           push;

  // nibble and separator decode
  always_comb begin
    item = '{cls: hwp_pkg::CLS_BAD, nib: 4'd0, wild: 1'b0};
    if (char_in_i == hwp_pkg::CH_NUL) begin
      item.cls = hwp_pkg::CLS_NUL;
    end else if (char_in_i == hwp_pkg::CH_SPACE || char_in_i == hwp_pkg::CH_TAB) begin
      item.cls = hwp_pkg::CLS_SEP;
    end else if (char_in_i == hwp_pkg::CH_WILD) begin
      item.cls  = hwp_pkg::CLS_NIB;
      item.wild = 1'b1;
    end else if (char_in_i >= 8'h30 && char_in_i <= 8'h39) begin
      item.cls = hwp_pkg::CLS_NIB;
      item.nib = char_in_i[3:0];
    end else if ((char_in_i >= 8'h61 && char_in_i <= 8'h66) ||
                 (char_in_i >= 8'h41 && char_in_i <= 8'h46)) begin
      item.cls = hwp_pkg::CLS_NIB;
      item.nib = 4'(char_in_i[2:0] + 3'd1) + 4'd8;
    end
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_q[rptr_q];

  // two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

@@ src/hwp_back.sv @@
// back end: token state machine that turns classified items into results
module hwp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hwp_pkg::TOTAL_W-1:0] cap_i,
  input  logic                        head_valid_i,
  input  hwp_pkg::item_t              head_i,
  output logic                        pop_o,
  input  logic                        room_i,
  output hwp_pkg::oq_wr_t             wr_o
);

  logic [1:0]                  phase_q, phase_d;
  logic [3:0]                  nib_q, nib_d;
  logic                        wild_q, wild_d;
  logic [hwp_pkg::TOTAL_W-1:0] cnt_q, cnt_d;
  logic                        full;
  logic [hwp_pkg::TOTAL_W-1:0] cnt_inc;
  logic [7:0]                  tok_val, tok_msk;
  hwp_pkg::res_t               r_byte, r_end_inc, r_end, r_bad;

  assign pop_o   = head_valid_i && room_i;
  assign full    = (cnt_q >= cap_i);
  assign cnt_inc = cnt_q + 1'b1;

  // token value and mask, lone nibble or pair
  always_comb begin
    if (head_i.cls == hwp_pkg::CLS_NIB) begin
      tok_val = {nib_q, head_i.nib};
      tok_msk = {wild_q ? 4'h0 : 4'hF, head_i.wild ? 4'h0 : 4'hF};
    end else begin
      tok_val = wild_q ? 8'h00 : {4'h0, nib_q};
      tok_msk = wild_q ? 8'h00 : 8'hFF;
    end
  end

  // result templates
  assign r_byte    = '{kind: hwp_pkg::KIND_BYTE, value: tok_val, mask: tok_msk,
                       total: cnt_inc, last: 1'b0};
  assign r_end     = '{kind: hwp_pkg::KIND_END, value: 8'h00, mask: 8'h00,
                       total: cnt_q, last: 1'b1};
  assign r_end_inc = '{kind: hwp_pkg::KIND_END, value: 8'h00, mask: 8'h00,
                       total: cnt_inc, last: 1'b1};
  assign r_bad     = '{kind: hwp_pkg::KIND_BAD, value: 8'h00, mask: 8'h00,
                       total: cnt_q, last: 1'b1};

  // next state and results for the item at the head
  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    wild_d    = wild_q;
    cnt_d     = cnt_q;
    wr_o.num  = 2'd0;
    wr_o.r0   = r_end;
    wr_o.r1   = r_end_inc;
    if (pop_o) begin
      case (phase_q)
        hwp_pkg::PH_DISCARD: begin
          if (head_i.cls == hwp_pkg::CLS_NUL) begin
            phase_d = hwp_pkg::PH_IDLE;
            cnt_d   = '0;
          end
        end
        hwp_pkg::PH_HELD: begin
          if (head_i.cls == hwp_pkg::CLS_BAD) begin
            wr_o.num = 2'd1;
            wr_o.r0  = r_bad;
            phase_d  = hwp_pkg::PH_DISCARD;
          end else begin
            // a token completes
            wr_o.num = 2'd1;
            if (full) begin
              wr_o.r0 = r_end;
              phase_d = hwp_pkg::PH_DISCARD;
            end else begin
              wr_o.r0 = r_byte;
              cnt_d   = cnt_inc;
              phase_d = hwp_pkg::PH_IDLE;
            end
            if (head_i.cls == hwp_pkg::CLS_NUL) begin
              if (!full) begin
                wr_o.num = 2'd2;
              end
              phase_d = hwp_pkg::PH_IDLE;
              cnt_d   = '0;
            end
          end
        end
        default: begin
          phase_d = hwp_pkg::PH_IDLE;
          case (head_i.cls)
            hwp_pkg::CLS_NUL: begin
              wr_o.num = 2'd1;
              wr_o.r0  = r_end;
              cnt_d    = '0;
            end
            hwp_pkg::CLS_BAD: begin
              wr_o.num = 2'd1;
              wr_o.r0  = r_bad;
              phase_d  = hwp_pkg::PH_DISCARD;
            end
            hwp_pkg::CLS_NIB: begin
              nib_d   = head_i.nib;
              wild_d  = head_i.wild;
              phase_d = hwp_pkg::PH_HELD;
            end
            default: begin
              phase_d = hwp_pkg::PH_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hwp_pkg::PH_IDLE;
      nib_q   <= 4'd0;
      wild_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      wild_q  <= wild_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ src/hwp_outq.sv @@
// output queue: takes up to two results a cycle, hands out one per item
module hwp_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hwp_pkg::oq_wr_t wr_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hwp_pkg::res_t   res_o
);

  localparam int unsigned PW = hwp_pkg::OQ_PTR_W;
  localparam int unsigned CW = PW + 1;

  hwp_pkg::res_t   mem_q [hwp_pkg::OQ_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign res_o       = mem_q[rptr_q];
  assign room_o      = (cnt_q <= CW'(hwp_pkg::OQ_DEPTH - 2));

  // result storage, second result lands after the first
  always_ff @(posedge clk_i) begin
    if (wr_i.num != 2'd0) begin
      mem_q[wptr_q] <= wr_i.r0;
    end
    if (wr_i.num == 2'd2) begin
      mem_q[wptr_q + 1'b1] <= wr_i.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + PW'(wr_i.num);
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(wr_i.num) - CW'(pop);
    end
  end

endmodule

@@ src/hex_wildcard_pattern_parser_core.sv @@
// top level of the hex wildcard pattern parser
// a character waits in the front queue; the back end writes its results into the output queue
// throughput: one character per cycle unless either queue holds it back; a NUL that closes a held token
//   writes two results, which leave the output queue one per cycle while out_ready_i is high
// the front queue (two items) and output queue (four results) decouple the two sides
// reset clears both queues and the token state and sets capacity to 256 (bounded by MAX_CAPACITY)
module hex_wildcard_pattern_parser_core #(
  parameter int unsigned MAX_CAPACITY = hwp_pkg::MAX_CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hwp_pkg::CHAR_W-1:0]  char_in_i,
  input  logic                        cfg_we_i,
  input  logic [hwp_pkg::TOTAL_W-1:0] cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hwp_pkg::KIND_W-1:0]  kind_o,
  output logic [hwp_pkg::BYTE_W-1:0]  byte_value_o,
  output logic [hwp_pkg::BYTE_W-1:0]  byte_mask_o,
  output logic [hwp_pkg::TOTAL_W-1:0] byte_total_o,
  output logic                        last_o
);

  localparam int unsigned CapRst = (hwp_pkg::CAP_RESET > MAX_CAPACITY) ?
                                   MAX_CAPACITY : hwp_pkg::CAP_RESET;

  logic [hwp_pkg::TOTAL_W-1:0] cap_q, cap_d;
  logic                        head_valid, pop, room;
  hwp_pkg::item_t              head;
  hwp_pkg::oq_wr_t             wr;
  hwp_pkg::res_t               res;

  // capacity register, saturated on write
  always_comb begin
    cap_d = cap_q;
    if (cfg_we_i) begin
      cap_d = (32'(cfg_data_i) > 32'(MAX_CAPACITY)) ? hwp_pkg::TOTAL_W'(MAX_CAPACITY)
                                                    : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= hwp_pkg::TOTAL_W'(CapRst);
    end else begin
      cap_q <= cap_d;
    end
  end

  hwp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  hwp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .room_i       (room),
    .wr_o         (wr)
  );

  hwp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // result fields
  assign kind_o       = res.kind;
  assign byte_value_o = res.value;
  assign byte_mask_o  = res.mask;
  assign byte_total_o = res.total;
  assign last_o       = res.last;

endmodule

@@ src/hwp_checker.sv @@
// port-level checker for the hex wildcard pattern parser, with its bind
module hwp_port_checks (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [hwp_pkg::KIND_W-1:0]  kind_o,
  input logic [hwp_pkg::BYTE_W-1:0]  byte_value_o,
  input logic [hwp_pkg::BYTE_W-1:0]  byte_mask_o,
  input logic [hwp_pkg::TOTAL_W-1:0] byte_total_o,
  input logic                        last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(byte_value_o) && $stable(byte_mask_o) && $stable(byte_total_o) && $stable(last_o))
    else $error("result changed while stalled");

  // only end and malformed results close a pattern
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != hwp_pkg::KIND_BYTE)))
    else $error("last flag does not match kind");

  // a pattern byte always counts itself
  a_byte_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == hwp_pkg::KIND_BYTE |-> byte_total_o != '0)
    else $error("pattern byte with zero total");

  // closing results carry no byte
  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != hwp_pkg::KIND_BYTE |-> byte_value_o == '0 && byte_mask_o == '0)
    else $error("closing result with nonzero byte");

endmodule

bind hex_wildcard_pattern_parser_core hwp_port_checks u_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .byte_value_o (byte_value_o),
  .byte_mask_o  (byte_mask_o),
  .byte_total_o (byte_total_o),
  .last_o       (last_o)
);
